// ===== hdl/nps_pkg.sv =====
package nps_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0]  TOP_PRIORITY = 3'd4;
  localparam logic [2:0]  LOW_PRIORITY = 3'd1;
  localparam logic [15:0] TIME_MAX     = 16'hFFFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] proc_name;
    logic [2:0] proc_priority;
    logic [7:0] arrival_time;
    logic [7:0] run_time;
  } in_item_t;

  typedef struct packed {
    logic        load_ok;
    logic        ran;
    logic [7:0]  ran_name;
    logic        started;
    logic        finished;
    logic [15:0] tick_time;
  } out_item_t;

  typedef struct packed {
    logic [7:0] name;
    logic [2:0] priority_lvl;
    logic [7:0] arrival;
    logic [7:0] remaining;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN_RD,
    ST_RUN_EX,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/nonpreemptive_priority_scheduler.sv =====
// Non-preemptive highest-priority-first job scheduler.
// Input channel (in_valid/in_ready/in_data) takes one item at a time: a load
// appends a job to a 16-entry table in load order unless it is full, a tick
// runs one quantum. Output channel (out_valid/out_ready/out_data) returns
// exactly one result per item, held in an output register until the receiver
// takes it. A tick with no running job scans the table through the single
// read port of the job memory, one entry per cycle.
// in_ready is high only in the idle state, so one item is in flight; the
// next item can be taken while the previous result still waits at the output.
// A stalled receiver holds the result; a further result waits inside until
// the output register frees up.
// Reset clears the job count, the running flag and the quantum counter; the
// table contents are not cleared, since only loaded entries are read.
module nonpreemptive_priority_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nps_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nps_pkg::out_item_t out_data
);

  nps_pkg::state_t state, state_next;

  nps_pkg::job_t mem [nps_pkg::MAX_ENTRIES];
  nps_pkg::job_t rd_data;
  logic [nps_pkg::IDX_W-1:0] rd_addr;
  logic                      wr_en;
  logic [nps_pkg::IDX_W-1:0] wr_addr;
  nps_pkg::job_t             wr_data;

  logic [nps_pkg::CNT_W-1:0] entry_count, entry_count_next;
  logic                      running_flag, running_flag_next;
  logic [nps_pkg::IDX_W-1:0] running_index, running_index_next;
  logic [15:0]               current_time, current_time_next;

  logic [nps_pkg::CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic                      cmp_vld, cmp_vld_next;
  logic [nps_pkg::IDX_W-1:0] cmp_idx, cmp_idx_next;
  logic                      best_vld, best_vld_next;
  logic [nps_pkg::IDX_W-1:0] best_idx, best_idx_next;
  logic [2:0]                best_pri, best_pri_next;
  logic [nps_pkg::IDX_W-1:0] sel_idx, sel_idx_next;
  logic                      sel_start, sel_start_next;

  nps_pkg::out_item_t res, res_next;
  logic               out_valid_next;
  nps_pkg::out_item_t out_data_next;

  logic       in_xfer;
  logic       elig;
  logic [7:0] rem_dec;

  assign in_ready = (state == nps_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign rem_dec  = rd_data.remaining - 8'd1;

  // Candidate beats the current best only on strictly higher priority, so the
  // earliest entry wins among equals.
  assign elig = cmp_vld
             && (rd_data.priority_lvl >= nps_pkg::LOW_PRIORITY)
             && (rd_data.priority_lvl <= nps_pkg::TOP_PRIORITY)
             && ({8'd0, rd_data.arrival} <= current_time)
             && (rd_data.remaining != 8'd0)
             && (rd_data.priority_lvl > best_pri);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nps_pkg::ST_IDLE;
      entry_count   <= '0;
      running_flag  <= 1'b0;
      running_index <= '0;
      current_time  <= '0;
      cmp_vld       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      running_flag  <= running_flag_next;
      running_index <= running_index_next;
      current_time  <= current_time_next;
      cmp_vld       <= cmp_vld_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt  <= scan_cnt_next;
    cmp_idx   <= cmp_idx_next;
    best_vld  <= best_vld_next;
    best_idx  <= best_idx_next;
    best_pri  <= best_pri_next;
    sel_idx   <= sel_idx_next;
    sel_start <= sel_start_next;
    res       <= res_next;
    out_data  <= out_data_next;
  end

  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    running_flag_next  = running_flag;
    running_index_next = running_index;
    current_time_next  = current_time;
    scan_cnt_next      = scan_cnt;
    cmp_vld_next       = 1'b0;
    cmp_idx_next       = cmp_idx;
    best_vld_next      = best_vld;
    best_idx_next      = best_idx;
    best_pri_next      = best_pri;
    sel_idx_next       = sel_idx;
    sel_start_next     = sel_start;
    res_next           = res;
    rd_addr            = sel_idx;
    wr_en              = 1'b0;
    wr_addr            = entry_count[nps_pkg::IDX_W-1:0];
    wr_data            = rd_data;
    out_valid_next     = out_valid && !out_ready;
    out_data_next      = out_data;

    unique case (state)
      nps_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_next = '0;
          if (in_data.cmd == nps_pkg::CMD_LOAD) begin
            if (entry_count < nps_pkg::CNT_W'(nps_pkg::MAX_ENTRIES)) begin
              wr_en                = 1'b1;
              wr_data.name         = in_data.proc_name;
              wr_data.priority_lvl = in_data.proc_priority;
              wr_data.arrival      = in_data.arrival_time;
              wr_data.remaining    = in_data.run_time;
              entry_count_next     = entry_count + 1'b1;
              res_next.load_ok     = 1'b1;
            end
            state_next = nps_pkg::ST_EMIT;
          end else begin
            res_next.tick_time = current_time;
            if (running_flag) begin
              sel_idx_next   = running_index;
              sel_start_next = 1'b0;
              state_next     = nps_pkg::ST_RUN_RD;
            end else begin
              scan_cnt_next = '0;
              best_vld_next = 1'b0;
              best_pri_next = '0;
              state_next    = nps_pkg::ST_SCAN;
            end
          end
        end
      end

      nps_pkg::ST_SCAN: begin
        if (elig) begin
          best_vld_next = 1'b1;
          best_idx_next = cmp_idx;
          best_pri_next = rd_data.priority_lvl;
        end
        if (scan_cnt < entry_count) begin
          // issue the next table read; its compare lands next cycle
          rd_addr       = scan_cnt[nps_pkg::IDX_W-1:0];
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = scan_cnt[nps_pkg::IDX_W-1:0];
          scan_cnt_next = scan_cnt + 1'b1;
        end else if (!cmp_vld) begin
          if (best_vld) begin
            sel_idx_next   = best_idx;
            sel_start_next = 1'b1;
            state_next     = nps_pkg::ST_RUN_RD;
          end else begin
            if (current_time != nps_pkg::TIME_MAX) begin
              current_time_next = current_time + 16'd1;
            end
            state_next = nps_pkg::ST_EMIT;
          end
        end
      end

      nps_pkg::ST_RUN_RD: begin
        rd_addr    = sel_idx;
        state_next = nps_pkg::ST_RUN_EX;
      end

      nps_pkg::ST_RUN_EX: begin
        if (!sel_start && rd_data.remaining == 8'd0) begin
          // stale running job: drop it and fall back to a full scan
          running_flag_next = 1'b0;
          scan_cnt_next     = '0;
          best_vld_next     = 1'b0;
          best_pri_next     = '0;
          state_next        = nps_pkg::ST_SCAN;
        end else begin
          wr_en              = 1'b1;
          wr_addr            = sel_idx;
          wr_data.remaining  = rem_dec;
          res_next.ran       = 1'b1;
          res_next.ran_name  = rd_data.name;
          res_next.started   = sel_start;
          res_next.finished  = (rem_dec == 8'd0);
          running_flag_next  = (rem_dec != 8'd0);
          running_index_next = sel_idx;
          if (current_time != nps_pkg::TIME_MAX) begin
            current_time_next = current_time + 16'd1;
          end
          state_next = nps_pkg::ST_EMIT;
        end
      end

      nps_pkg::ST_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = nps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= nps_pkg::CNT_W'(nps_pkg::MAX_ENTRIES))
    else $error("job count beyond table size");

  a_running_loaded: assert property (@(posedge clk) disable iff (rst)
    running_flag |-> ({1'b0, running_index} < entry_count))
    else $error("running job outside loaded entries");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nps_pkg::ST_SCAN) |-> (scan_cnt <= entry_count))
    else $error("scan ran past loaded entries");

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    (state == nps_pkg::ST_EMIT && (!out_valid || out_ready))
      |=> (out_valid && state == nps_pkg::ST_IDLE))
    else $error("result not moved to output register");

endmodule
